### rtl/bpsc_pkg.sv
package bpsc_pkg;

	localparam int MAX_PAIRS = 32;
	localparam int ID_BITS   = 32;
	localparam int FIELD_W   = 32;
	localparam int LEN_W     = 6;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam int S_TDATA_W = 2 * FIELD_W;
	localparam int RUN_W     = 2 * FIELD_W + LEN_W;
	localparam int M_TDATA_W = ((RUN_W + 7) / 8) * 8;

	typedef logic [ID_BITS-1:0] id_t;

	typedef struct packed {
		id_t src;
		id_t dst;
	} pair_t;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic consume;
		logic done;
	} merge_sts_t;

	typedef struct packed {
		logic [FIELD_W-1:0] src;
		logic [FIELD_W-1:0] dst;
		logic [LEN_W-1:0]   len;
		logic               last;
		logic               ovf;
	} run_t;

endpackage

### rtl/bpsc_cell.sv
module bpsc_cell
	import bpsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  pair_t     new_pair,
	input  pair_t     left_pair,
	input  logic      left_valid,
	input  logic      left_take,
	input  pair_t     right_pair,
	input  logic      right_valid,
	output pair_t     pair,
	output logic      valid,
	output logic      take
);

	pair_t pair_q;
	logic  valid_q;

	// take: the new pair belongs here or further towards the head
	assign take  = !valid_q || (pair_q.src > new_pair.src);
	assign pair  = pair_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (left_take) begin
				valid_q <= left_valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_take) begin
				pair_q <= left_pair;
			end else if (take) begin
				pair_q <= new_pair;
			end
		end else if (ctl.shift) begin
			pair_q <= right_pair;
		end
	end

endmodule

### rtl/bpsc_merge.sv
module bpsc_merge
	import bpsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       drain,
	input  pair_t      head_pair,
	input  logic       head_valid,
	input  logic       ovf,
	input  logic       out_ready,
	output merge_sts_t sts,
	output logic       out_valid,
	output run_t       out_run
);

	logic             run_valid_q;
	id_t              start_src_q;
	id_t              start_dst_q;
	id_t              last_src_q;
	id_t              last_dst_q;
	logic [LEN_W-1:0] len_q;
	logic             out_valid_q;
	run_t             out_run_q;

	logic out_free;
	logic cont;
	logic emit_brk;
	logic emit_fin;

	assign out_free = !out_valid_q || out_ready;
	assign cont     = run_valid_q
	                  && (head_pair.src == id_t'(last_src_q + 1'b1))
	                  && (head_pair.dst == id_t'(last_dst_q + 1'b1));
	assign emit_brk = drain && head_valid && run_valid_q && !cont && out_free;
	assign emit_fin = drain && !head_valid && run_valid_q && out_free;

	assign sts.consume = drain && head_valid && (!run_valid_q || cont || out_free);
	assign sts.done    = emit_fin;
	assign out_valid   = out_valid_q;
	assign out_run     = out_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fin) begin
				run_valid_q <= 1'b0;
			end else if (sts.consume) begin
				run_valid_q <= 1'b1;
			end
			if (emit_brk || emit_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_brk || emit_fin) begin
			out_run_q.src  <= FIELD_W'(start_src_q);
			out_run_q.dst  <= FIELD_W'(start_dst_q);
			out_run_q.len  <= len_q;
			out_run_q.last <= emit_fin;
			out_run_q.ovf  <= ovf;
		end
		if (sts.consume) begin
			last_src_q <= head_pair.src;
			last_dst_q <= head_pair.dst;
			if (cont) begin
				// saturate the length
				len_q <= len_q + LEN_W'(len_q != LEN_MAX);
			end else begin
				start_src_q <= head_pair.src;
				start_dst_q <= head_pair.dst;
				len_q       <= LEN_W'(1);
			end
		end
	end

endmodule

### rtl/block_pair_sort_coalesce.sv
// Sorts a batch of (source block, destination block) pairs by source id and
// returns them merged into runs in which both ids step up by one. Pairs enter
// on the s_ side, one beat per cycle with no gaps required while s_tready is
// high; each is placed at once into a chain of MAX_PAIRS sorting cells. Pairs
// with equal source ids keep their order of arrival and never merge with each
// other. The beat carrying s_tlast closes the batch: s_tready then drops while
// the chain shifts its contents towards the head into the run merger, one pair
// per cycle except while a finished run waits behind an output beat that
// m_tready has not yet taken. Each run leaves as one m_ beat; m_tlast marks
// the final run of the batch. Pairs that arrive while all cells are full are
// dropped, and m_tuser is then high on every run of that batch. s_tready
// returns high in the cycle after the final run is loaded into the output
// register.
module block_pair_sort_coalesce
	import bpsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // src_block, dst_block
	input  logic                 s_tlast,   // batch_last
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // run_src, run_dst, run_length, zero pad
	output logic                 m_tlast,   // run_last
	output logic                 m_tuser    // overflow
);

	typedef enum logic {
		FILL,
		DRAIN
	} state_t;

	state_t state_q;
	logic   overflow_q;

	cell_ctl_t  ctl;
	merge_sts_t msts;
	pair_t      new_pair;
	logic       accept;
	logic       full;
	run_t       run;

	pair_t                cell_pair   [MAX_PAIRS];
	pair_t                left_pair   [MAX_PAIRS];
	pair_t                right_pair  [MAX_PAIRS];
	logic [MAX_PAIRS-1:0] cell_valid;
	logic [MAX_PAIRS-1:0] cell_take;
	logic [MAX_PAIRS-1:0] left_valid;
	logic [MAX_PAIRS-1:0] left_take;
	logic [MAX_PAIRS-1:0] right_valid;

	// ids are taken modulo 2^ID_BITS
	assign new_pair.src = ID_BITS'(s_tdata[FIELD_W-1:0]);
	assign new_pair.dst = ID_BITS'(s_tdata[S_TDATA_W-1:FIELD_W]);

	assign s_tready = (state_q == FILL);
	assign accept   = s_tvalid && s_tready;
	// the tail cell holds a pair only once every cell does
	assign full     = cell_valid[MAX_PAIRS-1];

	// insert the beat unless the chain is full; shift towards the head while
	// the merger takes pairs
	assign ctl.insert = accept && !full;
	assign ctl.shift  = msts.consume;

	for (genvar g = 0; g < MAX_PAIRS; g++) begin : g_chain
		if (g == 0) begin : g_head
			assign left_pair[g]  = '0;
			assign left_valid[g] = 1'b0;
			assign left_take[g]  = 1'b0;
		end else begin : g_mid
			assign left_pair[g]  = cell_pair[g-1];
			assign left_valid[g] = cell_valid[g-1];
			assign left_take[g]  = cell_take[g-1];
		end
		if (g == MAX_PAIRS - 1) begin : g_tail
			assign right_pair[g]  = '0;
			assign right_valid[g] = 1'b0;
		end else begin : g_body
			assign right_pair[g]  = cell_pair[g+1];
			assign right_valid[g] = cell_valid[g+1];
		end

		bpsc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_pair    (new_pair),
			.left_pair   (left_pair[g]),
			.left_valid  (left_valid[g]),
			.left_take   (left_take[g]),
			.right_pair  (right_pair[g]),
			.right_valid (right_valid[g]),
			.pair        (cell_pair[g]),
			.valid       (cell_valid[g]),
			.take        (cell_take[g])
		);
	end

	bpsc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.drain      (state_q == DRAIN),
		.head_pair  (cell_pair[0]),
		.head_valid (cell_valid[0]),
		.ovf        (overflow_q),
		.out_ready  (m_tready),
		.sts        (msts),
		.out_valid  (m_tvalid),
		.out_run    (run)
	);

	assign m_tdata = {(M_TDATA_W - RUN_W)'(0), run.len, run.dst, run.src};
	assign m_tlast = run.last;
	assign m_tuser = run.ovf;

	// batch control: collect until the last beat, drain until the final run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FILL;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				FILL: begin
					if (accept && full) begin
						overflow_q <= 1'b1;
					end
					if (accept && s_tlast) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (msts.done) begin
						state_q    <= FILL;
						overflow_q <= 1'b0;
					end
				end
				default: state_q <= FILL;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("cell chain holds a gap");

	a_shift_only_drain: assert property (@(posedge clk) disable iff (!arst_n)
		msts.consume |-> (state_q == DRAIN))
		else $error("chain shifted while collecting");

	a_done_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		msts.done |=> (s_tready && m_tvalid && m_tlast))
		else $error("final run not presented or input not reopened");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> $past(full))
		else $error("overflow set while cells were free");
`endif

endmodule

### tb/block_pair_sort_coalesce_tb.sv
module block_pair_sort_coalesce_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpsc_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_BEATS = 400;
	// allow twice over for the emission of a full store
	localparam int DRAIN_CYCLES = 2 * MAX_PAIRS + 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	// one pending input beat: a pair and its batch_last mark
	typedef struct packed {
		id_t  src;
		id_t  dst;
		logic last;
	} beat_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;   // src_block, dst_block
	logic                 s_tlast  = 1'b0; // batch_last
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // run_src, run_dst, run_length, zero pad
	logic                 m_tlast;         // run_last
	logic                 m_tuser;         // overflow

	// predictor state: the sorted pair store and its fill level
	pair_t       sorted_pairs [MAX_PAIRS];
	int unsigned pairs_held    = 0;
	bit          pairs_dropped = 1'b0;

	run_t        runs_due[$];   // runs still owed by the block, oldest first
	beat_t       pending[$];    // beats not yet offered on the input
	int unsigned beats_taken = 0;
	int unsigned beats_total = 0;
	int unsigned cycles      = 0;
	int          errors      = 0;
	bit          hold_off    = 1'b0;

	block_pair_sort_coalesce dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Idle percentages per third of the stimulus: sender light and receiver heavy,
	// then the other way round, then no idling at all.
	function automatic int gap_pct(bit receiver);
		int unsigned phase;
		phase = (beats_total == 0) ? 0 : beats_taken * 3 / beats_total;
		if (phase == 0)
			return receiver ? 63 : 16;
		if (phase == 1)
			return receiver ? 16 : 63;
		return 0;
	endfunction

	// Insert one accepted pair behind every stored pair with a source id not above
	// its own, so that equal sources keep their order of arrival. On the closing
	// beat walk the store, merge neighbours whose ids both step up by one, and
	// queue one run per merged stretch.
	function automatic void sort_pair_in(beat_t b);
		int unsigned pos;
		run_t        r;
		if (pairs_held >= MAX_PAIRS) begin
			// store full: drop the pair, flag the whole batch
			pairs_dropped = 1'b1;
		end else begin
			pos = pairs_held;
			while (pos > 0 && sorted_pairs[pos-1].src > b.src) begin
				sorted_pairs[pos] = sorted_pairs[pos-1];
				pos--;
			end
			sorted_pairs[pos] = '{src: b.src, dst: b.dst};
			pairs_held++;
		end
		if (!b.last)
			return;
		r = '{src: sorted_pairs[0].src, dst: sorted_pairs[0].dst, len: LEN_W'(1),
			last: 1'b0, ovf: pairs_dropped};
		for (int unsigned i = 1; i < pairs_held; i++) begin
			// the step of one wraps at the id width; equal sources never merge
			if (sorted_pairs[i].src == id_t'(sorted_pairs[i-1].src + 1) &&
				sorted_pairs[i].dst == id_t'(sorted_pairs[i-1].dst + 1)) begin
				if (r.len != LEN_MAX)
					r.len++;
			end else begin
				runs_due = {runs_due, r};
				r = '{src: sorted_pairs[i].src, dst: sorted_pairs[i].dst, len: LEN_W'(1),
					last: 1'b0, ovf: pairs_dropped};
			end
		end
		r.last = 1'b1;
		runs_due = {runs_due, r};
		pairs_held    = 0;
		pairs_dropped = 1'b0;
	endfunction

	function automatic void compare_field(string what, logic [FIELD_W-1:0] want,
		logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
			errors++;
		end
	endfunction

	task automatic queue_pair(id_t s, id_t d, logic last);
		beat_t b;
		b = '{src: s, dst: d, last: last};
		pending = {pending, b};
	endtask

	// Build one random batch. Most batches are runs with a random base that break
	// now and then (new destination, repeated source, skipped source); the rest
	// are pure noise, tiny ids that collide on the source, or ids close to the top
	// of the range so that the source wraps to zero. About one batch in ten fills
	// the store or overfills it.
	task automatic queue_batch();
		pair_t       batch[$];
		pair_t       p;
		pair_t       t;
		int unsigned size;
		int unsigned style;
		int unsigned j;
		bit          dense;
		size  = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAIRS, MAX_PAIRS + 4)
			: $urandom_range(1, 10);
		style = $urandom_range(5);
		dense = ($urandom_range(1) == 0);
		p     = '{src: $urandom(), dst: $urandom()};
		if (style == 5)
			p = '{src: {ID_BITS{1'b1}} - $urandom_range(40),
				dst: {ID_BITS{1'b1}} - $urandom_range(40)};
		for (int unsigned i = 0; i < size; i++) begin
			case (style)
			0: begin
				p = '{src: $urandom(), dst: $urandom()};
			end
			1: begin
				p = '{src: $urandom_range(7), dst: $urandom_range(7)};
			end
			default: begin
				if (i > 0) begin
					p.src = p.src + 1;
					p.dst = p.dst + 1;
					if (!dense && $urandom_range(3) == 0) begin
						case ($urandom_range(2))
						0:       p.dst = $urandom();
						1:       p.src = p.src - 1;
						default: p.src = p.src + $urandom_range(1, 3);
						endcase
					end
				end
			end
			endcase
			batch = {batch, p};
		end
		// scramble the arrival order for two batches in three
		if ($urandom_range(2) != 0) begin
			for (int unsigned i = size - 1; i > 0; i--) begin
				j        = $urandom_range(i);
				t        = batch[i];
				batch[i] = batch[j];
				batch[j] = t;
			end
		end
		foreach (batch[i])
			queue_pair(batch[i].src, batch[i].dst, i == size - 1);
	endtask

	// Input driver: predict on every accepted beat, then offer the next pending
	// pair unless the sender idles this cycle. Hold tvalid and the data while the
	// block stalls.
	always @(posedge clk or negedge arst_n) begin : drive
		beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				sort_pair_in('{src: s_tdata[FIELD_W-1:0],
					dst: s_tdata[S_TDATA_W-1:FIELD_W], last: s_tlast});
				beats_taken <= beats_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 && $urandom_range(99) >= gap_pct(1'b0)) begin
					b = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {b.dst, b.src};
					s_tlast  <= b.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check every accepted run against the oldest expectation,
	// then decide whether the receiver stalls in the next cycle.
	always @(posedge clk or negedge arst_n) begin : watch
		run_t got;
		run_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{src: m_tdata[FIELD_W-1:0],
					dst: m_tdata[2*FIELD_W-1:FIELD_W],
					len: m_tdata[2*FIELD_W+LEN_W-1:2*FIELD_W],
					last: m_tlast, ovf: m_tuser};
				if (runs_due.size() == 0) begin
					$display("%0t: unexpected run: expected none, actual src %h dst %h len %0d",
						$time, got.src, got.dst, got.len);
					errors++;
				end else begin
					want = runs_due.pop_front();
					compare_field("run_src", want.src, got.src);
					compare_field("run_dst", want.dst, got.dst);
					compare_field("run_length", FIELD_W'(want.len), FIELD_W'(got.len));
					compare_field("run_last", FIELD_W'(want.last), FIELD_W'(got.last));
					compare_field("overflow", FIELD_W'(want.ovf), FIELD_W'(got.ovf));
				end
			end
			m_tready <= !hold_off && $urandom_range(99) >= gap_pct(1'b1);
		end
	end

	// Back-pressure: late in the no-idle stretch, stall the receiver for a long
	// while so that a closed batch backs up and the input stalls behind it.
	initial begin
		@(posedge clk);
		while (beats_taken < beats_total * 7 / 8)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned directed;
		// lowest and highest ids, each a batch of one
		queue_pair('0, '0, 1'b1);
		queue_pair({ID_BITS{1'b1}}, {ID_BITS{1'b1}}, 1'b1);
		// descending arrival, equal sources kept apart, and a run whose
		// destination wraps from the largest id to zero
		queue_pair(12, 1, 1'b0);
		queue_pair(5, 6, 1'b0);
		queue_pair(11, 0, 1'b0);
		queue_pair(10, {ID_BITS{1'b1}}, 1'b0);
		queue_pair(5, 5, 1'b0);
		queue_pair(6, 7, 1'b1);
		// the largest source followed by zero sorts apart and does not merge
		queue_pair({ID_BITS{1'b1}}, 100, 1'b0);
		queue_pair('0, 101, 1'b1);
		// alternating bit patterns in both fields
		queue_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		queue_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		// a run in arrival order that merges fully
		queue_pair(32'h0001_0000, 32'h8000_0000, 1'b0);
		queue_pair(32'h0001_0001, 32'h8000_0001, 1'b0);
		queue_pair(32'h0001_0002, 32'h8000_0002, 1'b1);
		directed = pending.size();
		while (pending.size() < directed + RANDOM_BEATS)
			queue_batch();
		beats_total = pending.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last beat to go in and every run to come out
		while (pending.size() != 0 || s_tvalid || runs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
